### hdl/sha_pkg.sv
package sha_pkg;

	localparam int unsigned NUM_ROUNDS = 64;
	localparam int unsigned BLOCK_WORDS = 16;

	// controller state codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_PAD2  = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_ADD   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	// which block the compression belongs to
	localparam logic [1:0] PH_DATA = 2'd0;
	localparam logic [1:0] PH_PAD1 = 2'd1;
	localparam logic [1:0] PH_PAD2 = 2'd2;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	typedef struct packed {
		logic write_byte;
		logic pad1;
		logic pad2;
		logic load;
		logic round;
		logic add;
		logic out_step;
		logic clear_msg;
	} sha_cmd_t;

	typedef struct packed {
		logic block_full_next;
		logic pos_ge56;
		logic round_last;
		logic out_last;
	} sha_status_t;

	function automatic logic [31:0] initial_hash(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_const(input logic [5:0] t);
		logic [31:0] r;
		case (t)
			6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491;
			6'd2: r = 32'hb5c0fbcf; 6'd3: r = 32'he9b5dba5;
			6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5;
			6'd8: r = 32'hd807aa98; 6'd9: r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

### hdl/sha_ctrl.sv
module sha_ctrl import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	input  sha_status_t status,
	output sha_cmd_t    cmd
);

	logic [2:0] state_q, state_d;
	logic [1:0] phase_q, phase_d;
	logic       eom_q, eom_d;
	logic       two_q, two_d;
	logic       in_xfer;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_xfer   = in_valid && in_ready;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		eom_d   = eom_q;
		two_d   = two_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					cmd.write_byte = byte_present;
					if (byte_present && status.block_full_next) begin
						eom_d   = end_of_message;
						phase_d = PH_DATA;
						state_d = ST_LOAD;
					end else if (end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.pad1 = 1'b1;
				two_d    = status.pos_ge56;
				phase_d  = PH_PAD1;
				state_d  = ST_LOAD;
			end
			ST_PAD2: begin
				cmd.pad2 = 1'b1;
				phase_d  = PH_PAD2;
				state_d  = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (status.round_last) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				case (phase_q)
					PH_DATA: state_d = eom_q ? ST_PAD : ST_IDLE;
					PH_PAD1: state_d = two_q ? ST_PAD2 : ST_OUT;
					default: state_d = ST_OUT;
				endcase
			end
			ST_OUT: begin
				if (out_ready) begin
					cmd.out_step = 1'b1;
					if (status.out_last) begin
						cmd.clear_msg = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_DATA;
			eom_q   <= 1'b0;
			two_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			eom_q   <= eom_d;
			two_q   <= two_d;
		end
	end

endmodule

### hdl/sha_dp.sv
module sha_dp import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  sha_cmd_t    cmd,
	output sha_status_t status,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word
);

	logic [31:0] chain_q [8];
	logic [31:0] work_q [8];
	logic [31:0] win_q [BLOCK_WORDS];
	logic [31:0] pad_words [BLOCK_WORDS];
	logic [5:0]  count_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [63:0] len_now;
	logic [63:0] len_use;
	logic [5:0]  round_q;
	logic [2:0]  out_idx_q;
	logic [31:0] t1, t2, w_next;

	assign status.block_full_next = (count_q == 6'd63);
	assign status.pos_ge56        = (count_q >= LEN_POS);
	assign status.round_last      = (round_q == 6'(NUM_ROUNDS - 1));
	assign status.out_last        = (out_idx_q == 3'd7);

	assign digest_word = chain_q[out_idx_q];
	assign word_number = out_idx_q;
	assign final_word  = (out_idx_q == 3'd7);

	// message length in bits at the pad point
	assign len_now = bits_q + {55'd0, count_q, 3'b000};
	assign len_use = cmd.pad1 ? len_now : len_q;

	// padded block image: bytes at and above the pending count replaced, or the whole block for the second pad block
	always_comb begin
		logic [5:0] bi;
		logic [7:0] b;
		for (int i = 0; i < 64; i++) begin
			bi = 6'(i);
			if (cmd.pad1 && bi < count_q) begin
				b = win_q[i / 4][31 - 8 * (i % 4) -: 8];
			end else if (cmd.pad1 && bi == count_q) begin
				b = PAD_BYTE;
			end else begin
				b = 8'h00;
			end
			if (bi >= LEN_POS && (cmd.pad2 || count_q < LEN_POS)) begin
				b = len_use[8 * (7 - (i % 8)) +: 8];
			end
			pad_words[i / 4][31 - 8 * (i % 4) -: 8] = b;
		end
	end

	// one compression round and the schedule word entering the window
	always_comb begin
		t1 = work_q[7] + big_sigma1(work_q[4])
			+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
			+ round_const(round_q) + win_q[0];
		t2 = big_sigma0(work_q[0])
			+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
		w_next = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
	end

	// message window: byte writes, padding, schedule shift
	always_ff @(posedge clk) begin
		if (cmd.write_byte) begin
			win_q[count_q[5:2]][31 - 8 * count_q[1:0] -: 8] <= data_byte;
		end else if (cmd.pad1 || cmd.pad2) begin
			win_q <= pad_words;
		end else if (cmd.round) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[BLOCK_WORDS - 1] <= w_next;
		end
		if (cmd.pad1) begin
			len_q <= len_now;
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= chain_q;
		end else if (cmd.round) begin
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	// chaining value, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= initial_hash(3'(i));
			end
			count_q   <= '0;
			bits_q    <= '0;
			round_q   <= '0;
			out_idx_q <= '0;
		end else begin
			if (cmd.clear_msg) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= initial_hash(3'(i));
				end
				count_q <= '0;
				bits_q  <= '0;
			end else if (cmd.add) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end
			if (cmd.write_byte) begin
				count_q <= count_q + 6'd1;
				if (count_q == 6'd63) begin
					bits_q <= bits_q + 64'd512;
				end
			end
			if (cmd.load) begin
				round_q <= '0;
			end else if (cmd.round) begin
				round_q <= round_q + 6'd1;
			end
			if (cmd.out_step) begin
				out_idx_q <= out_idx_q + 3'd1;
			end
		end
	end

endmodule

### hdl/sha256_byte_stream_hasher.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   data_byte, byte_present, end_of_message
// out      output     out_valid / out_ready digest_word, word_number, final_word
//
// a plain byte is written into the block buffer; a byte that completes a 64-byte block
// also starts a compression (load, 64 rounds of the single round unit, add).
// the final item adds one or two padding compressions, then 8 output transfers.
// in_ready is low while a block compresses or the digest is being read out.
// out_valid holds each digest word until out_ready takes it.
// arst_n clears the controller and loads the initial hash values.
module sha256_byte_stream_hasher import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word
);

	sha_cmd_t    cmd;
	sha_status_t status;

	// sequencer
	sha_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.cmd            (cmd)
	);

	// block buffer, round unit and hash state
	sha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.status      (status),
		.digest_word (digest_word),
		.word_number (word_number),
		.final_word  (final_word)
	);

endmodule

### hdl/sha_checker.sv
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_number,
	input logic        final_word
);

	// input is never taken while a digest is being read out
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready during digest output");

	// final flag marks the last word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (final_word == (word_number == 3'd7)))
		else $error("final_word mismatch");

	// words come out in order
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !final_word) |=>
			(out_valid && word_number == 3'($past(word_number) + 3'd1)))
		else $error("digest word order broken");

	// digest ends after the final word transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && final_word) |=> (!out_valid && in_ready))
		else $error("output continues after final word");

	// stalled output word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(digest_word)))
		else $error("stalled digest word changed");

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.digest_word (digest_word),
	.word_number (word_number),
	.final_word  (final_word)
);

### tb/sha256_digest_checker.sv
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_number,
	input  logic        final_word,
	output int          fail_count,
	output int          words_pending
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_entry_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0]   hash_state [8];
	logic [7:0]    msg_block [64];
	int unsigned   block_fill;
	logic [63:0]   bit_total;
	digest_entry_t digest_queue [$];

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of msg_block into hash_state
	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
				+ (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
		v = hash_state;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endtask

	// absorb one transfer, queue the digest on end of message
	task automatic absorb_item(input logic [7:0] b, input logic has_byte, input logic eom);
		logic [63:0] len;
		if (has_byte) begin
			msg_block[block_fill] = b;
			block_fill++;
			if (block_fill == 64) begin
				compress();
				bit_total += 64'd512;
				block_fill = 0;
			end
		end
		if (eom) begin
			len = bit_total + 64'(block_fill) * 8;
			msg_block[block_fill] = 8'h80;
			for (int k = block_fill + 1; k < 64; k++)
				msg_block[k] = 8'h00;
			if (block_fill >= 56) begin
				compress();
				for (int k = 0; k < 56; k++)
					msg_block[k] = 8'h00;
			end
			for (int k = 0; k < 8; k++)
				msg_block[63-k] = len[8*k +: 8];
			compress();
			for (int k = 0; k < 8; k++)
				digest_queue.push_back('{hash_state[k], 3'(k), k == 7});
			hash_state = H_INIT;
			block_fill = 0;
			bit_total = '0;
		end
	endtask

	// predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		digest_entry_t exp_e;
		if (!arst_n) begin
			hash_state = H_INIT;
			block_fill = 0;
			bit_total = '0;
			fail_count = 0;
			digest_queue.delete();
		end else begin
			if (in_valid && in_ready)
				absorb_item(data_byte, byte_present, end_of_message);
			if (out_valid && out_ready) begin
				if (digest_queue.size() == 0) begin
					$error("unexpected digest transfer word %h", digest_word);
					fail_count++;
				end else begin
					exp_e = digest_queue.pop_front();
					if (digest_word !== exp_e.word) begin
						$error("digest_word expected %h actual %h", exp_e.word, digest_word);
						fail_count++;
					end
					if (word_number !== exp_e.index) begin
						$error("word_number expected %0d actual %0d", exp_e.index, word_number);
						fail_count++;
					end
					if (final_word !== exp_e.last) begin
						$error("final_word expected %0d actual %0d", exp_e.last, final_word);
						fail_count++;
					end
				end
			end
		end
		words_pending = digest_queue.size();
	end

endmodule

### tb/sha256_byte_stream_hasher_tb.sv
module sha256_byte_stream_hasher_tb;

	localparam int STALL_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        byte_present;
	logic        end_of_message;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        final_word;
	int          fail_count;
	int          words_pending;
	int          idle_cycles;
	int          msg_count;

	sha256_byte_stream_hasher u_dut (.*);

	sha256_digest_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// send one transfer after a random gap
	task automatic send_item(input logic [7:0] b, input logic has_byte, input logic eom);
		int gap;
		gap = $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom);
			byte_present <= 1'($urandom);
			end_of_message <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_present <= has_byte;
		end_of_message <= eom;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// a message of n bytes, plus a tail byte when tail_byte is set, with random content and occasional empty items
	task automatic send_message(input int n, input logic tail_byte);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, 1'b0);
		end
		send_item(8'($urandom), tail_byte, 1'b1);
	endtask

	// receiver stalls
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (out_ready && out_valid) begin
				out_ready <= 1'b0;
			end else if (!out_ready) begin
				repeat ($urandom_range(0, 8)) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else if (++idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		byte_present = 1'b0;
		end_of_message = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty message, extreme bytes, padding boundaries
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'ha5, 1'b1, 1'b1);
		in_valid <= 1'b0;
		// sender holds off until every digest word has left
		wait (words_pending == 0);
		send_message(54, 1'b1);
		send_message(56, 1'b0);
		send_message(63, 1'b1);
		send_message(64, 1'b0);

		// a few short random messages
		msg_count = 0;
		while (msg_count < 3) begin
			send_message($urandom_range(0, 12), 1'($urandom));
			msg_count++;
		end
		in_valid <= 1'b0;

		wait (words_pending == 0);
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### sim.f
hdl/sha_pkg.sv
hdl/sha_ctrl.sv
hdl/sha_dp.sv
hdl/sha256_byte_stream_hasher.sv
hdl/sha_checker.sv
tb/sha256_digest_checker.sv
tb/sha256_byte_stream_hasher_tb.sv
